### sv/c2e_pkg.sv
// ----------------------------------------------------------------------------
// c2e_pkg
// Shared widths, constants and the month table for the calendar to epoch
// seconds converter.
// ----------------------------------------------------------------------------
package c2e_pkg;

  // pipeline depth, output register included
  localparam int NumStages = 5;

  // port field widths
  localparam int YearW = 14;
  localparam int MonW  = 4;
  localparam int DayW  = 6;
  localparam int HourW = 5;
  localparam int MinW  = 6;
  localparam int SecW  = 6;
  localparam int SecsW = 39;

  // internal widths
  localparam int TodW    = 17;  // seconds in a day, up to 86400
  localparam int DayCntW = 22;  // days since the epoch, up to about 3.63e6
  localparam int LeapW   = 12;  // leap days before the year
  localparam int DbmW    = 9;   // days before the month
  localparam int CentW   = 7;   // a year divided by 100
  localparam int ProdW   = YearW + 13;

  localparam logic [YearW-1:0] YearBase   = YearW'(1900);
  localparam logic [YearW-1:0] EpochYear  = YearW'(1970);
  localparam logic [YearW-1:0] LeapBase4  = YearW'(1969);
  localparam logic [YearW-1:0] LeapBase100 = YearW'(1901);
  localparam logic [YearW-1:0] MinYearOff = YearW'(70);
  localparam logic [YearW-1:0] MaxYearOff = YearW'(9999);
  localparam logic [MonW-1:0]  MaxMonth   = MonW'(11);
  localparam logic [MonW-1:0]  Feb        = MonW'(1);
  localparam logic [DayW-1:0]  MaxDay     = DayW'(31);
  localparam logic [HourW-1:0] MaxHour    = HourW'(23);
  localparam logic [MinW-1:0]  MaxMinute  = MinW'(59);
  localparam logic [SecW-1:0]  MaxSecond  = SecW'(60);

  localparam int DaysPerYear = 365;
  localparam int SecsPerHour = 3600;
  localparam int SecsPerMin  = 60;
  localparam int SecsPerDay  = 60 * 60 * 24;

  // x / 100 == (x * 5243) >> 19 for every x below 43699
  localparam logic [12:0] Recip100   = 13'd5243;
  localparam int          RecipShift = 19;

  // stage load strobes and fill flags handed from flow control to the datapath
  typedef struct packed {
    logic [NumStages-1:0] load;
    logic [NumStages-1:0] full;
  } flow_t;

  function automatic logic [DbmW-1:0] days_before_month(input logic [MonW-1:0] mon);
    logic [DbmW-1:0] d;
    case (mon)
      MonW'(0):  d = DbmW'(0);
      MonW'(1):  d = DbmW'(31);
      MonW'(2):  d = DbmW'(59);
      MonW'(3):  d = DbmW'(90);
      MonW'(4):  d = DbmW'(120);
      MonW'(5):  d = DbmW'(151);
      MonW'(6):  d = DbmW'(181);
      MonW'(7):  d = DbmW'(212);
      MonW'(8):  d = DbmW'(243);
      MonW'(9):  d = DbmW'(273);
      MonW'(10): d = DbmW'(304);
      MonW'(11): d = DbmW'(334);
      default:   d = DbmW'(0);
    endcase
    return d;
  endfunction

endpackage

### sv/c2e_if.sv
// ----------------------------------------------------------------------------
// c2e_if
// Valid/ready channels: broken-down time in, epoch seconds out.
// ----------------------------------------------------------------------------
interface c2e_req_if;
  logic                         valid;
  logic                         ready;
  logic [c2e_pkg::YearW-1:0]    years_since_1900;
  logic [c2e_pkg::MonW-1:0]     month_index;
  logic [c2e_pkg::DayW-1:0]     day_of_month;
  logic [c2e_pkg::HourW-1:0]    hour_of_day;
  logic [c2e_pkg::MinW-1:0]     minute_of_hour;
  logic [c2e_pkg::SecW-1:0]     second_of_minute;

  modport source (
    output valid, years_since_1900, month_index, day_of_month,
           hour_of_day, minute_of_hour, second_of_minute,
    input  ready
  );
  modport sink (
    input  valid, years_since_1900, month_index, day_of_month,
           hour_of_day, minute_of_hour, second_of_minute,
    output ready
  );
endinterface

interface c2e_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [c2e_pkg::SecsW-1:0]    epoch_seconds;
  logic                         range_error;

  modport source (output valid, epoch_seconds, range_error, input ready);
  modport sink (input valid, epoch_seconds, range_error, output ready);
endinterface

### sv/c2e_flow.sv
// ----------------------------------------------------------------------------
// c2e_flow
// Per-stage valid tracking and load strobes for the conversion pipeline.
// ----------------------------------------------------------------------------
module c2e_flow (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            out_ready,
  output logic            in_ready,
  output c2e_pkg::flow_t  ctl
);

  localparam int N = c2e_pkg::NumStages;

  logic [N-1:0] full;
  logic [N-1:0] full_in;
  logic [N:0]   rdy;

  // a stage may load when it is empty or its contents move on this cycle
  always_comb begin
    rdy[N] = out_ready;
    for (int i = N - 1; i >= 0; i--) begin
      rdy[i] = !full[i] || rdy[i+1];
    end
  end

  assign full_in  = {full[N-2:0], in_valid};
  assign in_ready = rdy[0];
  assign ctl.load = rdy[N-1:0];
  assign ctl.full = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= '0;
    end else begin
      full <= (full & ~rdy[N-1:0]) | (full_in & rdy[N-1:0]);
    end
  end

  // a transaction in with none out adds exactly one occupied stage
  a_fill_count: assert property (@(posedge clk) disable iff (rst)
    (in_valid && rdy[0] && !(full[N-1] && out_ready))
      |=> ($countones(full) == $past($countones(full)) + 1))
    else $error("occupancy did not grow by one");

  // the input side only stalls when every stage holds an item
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !rdy[0] |-> (&full))
    else $error("input stalled with an empty stage");

endmodule

### sv/calendar_to_epoch_seconds.sv
// An accepted transaction passes through five register stages, the last
// driving rsp. Throughput: one transaction per cycle while rsp is ready;
// each stage holds one item and moves on whenever the stage after it is free.
// Reset (rst, synchronous) clears the stage valid bits only; datapath
// registers keep whatever they hold and are ignored until refilled.
// ----------------------------------------------------------------------------
// calendar_to_epoch_seconds
// Converts a broken-down UTC calendar time into seconds since 1970-01-01,
// flagging out-of-range fields with a zero result.
// ----------------------------------------------------------------------------
module calendar_to_epoch_seconds (
  input logic         clk,
  input logic         rst,
  c2e_req_if.sink     req,
  c2e_rsp_if.source   rsp
);

  c2e_pkg::flow_t flow;

  c2e_flow u_flow (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .out_ready (rsp.ready),
    .in_ready  (req.ready),
    .ctl       (flow)
  );

  // --------------------------------------------------------------------------
  // Stage 1: range check, absolute year, time of day in seconds
  // --------------------------------------------------------------------------
  logic                         s1_err_next;
  logic [c2e_pkg::TodW-1:0]     s1_tod_next;
  logic                         s1_err;
  logic [c2e_pkg::YearW-1:0]    s1_y;
  logic [c2e_pkg::MonW-1:0]     s1_mon;
  logic [c2e_pkg::DayW-1:0]     s1_mday;
  logic [c2e_pkg::TodW-1:0]     s1_tod;

  assign s1_err_next = (req.years_since_1900 < c2e_pkg::MinYearOff) ||
                       (req.years_since_1900 > c2e_pkg::MaxYearOff) ||
                       (req.month_index > c2e_pkg::MaxMonth) ||
                       (req.day_of_month == '0) ||
                       (req.day_of_month > c2e_pkg::MaxDay) ||
                       (req.hour_of_day > c2e_pkg::MaxHour) ||
                       (req.minute_of_hour > c2e_pkg::MaxMinute) ||
                       (req.second_of_minute > c2e_pkg::MaxSecond);

  // constant multiplies only; a leap second simply rolls into the next minute
  assign s1_tod_next =
      c2e_pkg::TodW'(req.hour_of_day) * c2e_pkg::TodW'(c2e_pkg::SecsPerHour) +
      c2e_pkg::TodW'(req.minute_of_hour) * c2e_pkg::TodW'(c2e_pkg::SecsPerMin) +
      c2e_pkg::TodW'(req.second_of_minute);

  always_ff @(posedge clk) begin
    if (flow.load[0]) begin
      s1_err  <= s1_err_next;
      s1_y    <= req.years_since_1900 + c2e_pkg::YearBase;
      s1_mon  <= req.month_index;
      s1_mday <= req.day_of_month;
      s1_tod  <= s1_tod_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: divide by 100 through reciprocal multiplies, month table lookup
  // --------------------------------------------------------------------------
  logic [c2e_pkg::ProdW-1:0]    prod_a;
  logic [c2e_pkg::ProdW-1:0]    prod_y;
  logic                         s2_err;
  logic [c2e_pkg::YearW-1:0]    s2_y;
  logic [c2e_pkg::CentW-1:0]    s2_qa;   // (y - 1901) / 100
  logic [c2e_pkg::CentW-1:0]    s2_qy;   // y / 100
  logic [c2e_pkg::DbmW-1:0]     s2_dbm;
  logic                         s2_past_feb;
  logic [c2e_pkg::DayW-1:0]     s2_mday;
  logic [c2e_pkg::TodW-1:0]     s2_tod;

  assign prod_a = c2e_pkg::ProdW'(s1_y - c2e_pkg::LeapBase100) *
                  c2e_pkg::ProdW'(c2e_pkg::Recip100);
  assign prod_y = c2e_pkg::ProdW'(s1_y) * c2e_pkg::ProdW'(c2e_pkg::Recip100);

  always_ff @(posedge clk) begin
    if (flow.load[1]) begin
      s2_err      <= s1_err;
      s2_y        <= s1_y;
      s2_qa       <= c2e_pkg::CentW'(prod_a >> c2e_pkg::RecipShift);
      s2_qy       <= c2e_pkg::CentW'(prod_y >> c2e_pkg::RecipShift);
      s2_dbm      <= c2e_pkg::days_before_month(s1_mon);
      s2_past_feb <= (s1_mon > c2e_pkg::Feb);
      s2_mday     <= s1_mday;
      s2_tod      <= s1_tod;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: leap days before the year, leap year test, whole-year days
  // --------------------------------------------------------------------------
  // leap days = (y-1969)/4 - (y-1901)/100 + (y-1601)/400, and
  // (y-1601)/400 equals ((y-1901)/100 + 3)/4.
  logic [c2e_pkg::YearW-1:0]    y_off4;
  logic [c2e_pkg::CentW-1:0]    qa_plus3;
  logic                         cent_year;
  logic                         leap_year;
  logic                         s3_err;
  logic [c2e_pkg::DayCntW-1:0]  s3_ydays;
  logic [c2e_pkg::LeapW-1:0]    s3_leap;
  logic [c2e_pkg::DbmW-1:0]     s3_dbm;
  logic                         s3_bump;
  logic [c2e_pkg::DayW-1:0]     s3_mday;
  logic [c2e_pkg::TodW-1:0]     s3_tod;

  assign y_off4    = s2_y - c2e_pkg::LeapBase4;
  assign qa_plus3  = s2_qa + c2e_pkg::CentW'(3);
  assign cent_year = (s2_y == c2e_pkg::YearW'(s2_qy) * c2e_pkg::YearW'(100));
  assign leap_year = (s2_y[1:0] == 2'b00) && (!cent_year || (s2_qy[1:0] == 2'b00));

  always_ff @(posedge clk) begin
    if (flow.load[2]) begin
      s3_err   <= s2_err;
      s3_ydays <= c2e_pkg::DayCntW'(s2_y - c2e_pkg::EpochYear) *
                  c2e_pkg::DayCntW'(c2e_pkg::DaysPerYear);
      s3_leap  <= c2e_pkg::LeapW'(y_off4 >> 2) - c2e_pkg::LeapW'(s2_qa) +
                  c2e_pkg::LeapW'(qa_plus3 >> 2);
      s3_dbm   <= s2_dbm;
      s3_bump  <= s2_past_feb && leap_year;
      s3_mday  <= s2_mday;
      s3_tod   <= s2_tod;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: total day count; the day is not checked against month length
  // --------------------------------------------------------------------------
  logic                         s4_err;
  logic [c2e_pkg::DayCntW-1:0]  s4_days;
  logic [c2e_pkg::TodW-1:0]     s4_tod;

  always_ff @(posedge clk) begin
    if (flow.load[3]) begin
      s4_err  <= s3_err;
      s4_days <= s3_ydays + c2e_pkg::DayCntW'(s3_leap) + c2e_pkg::DayCntW'(s3_dbm) +
                 c2e_pkg::DayCntW'(s3_mday) - c2e_pkg::DayCntW'(1) +
                 c2e_pkg::DayCntW'(s3_bump);
      s4_tod  <= s3_tod;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: days to seconds plus time of day; force zero on a range error.
  // This is the output register and drives rsp directly.
  // --------------------------------------------------------------------------
  logic [c2e_pkg::SecsW-1:0]    secs_next;
  logic [c2e_pkg::SecsW-1:0]    out_secs;
  logic                         out_err;

  assign secs_next = c2e_pkg::SecsW'(s4_days) * c2e_pkg::SecsW'(c2e_pkg::SecsPerDay) +
                     c2e_pkg::SecsW'(s4_tod);

  always_ff @(posedge clk) begin
    if (flow.load[4]) begin
      out_err  <= s4_err;
      out_secs <= s4_err ? '0 : secs_next;
    end
  end

  assign rsp.valid         = flow.full[c2e_pkg::NumStages-1];
  assign rsp.epoch_seconds = out_secs;
  assign rsp.range_error   = out_err;

  // a flagged result never carries a nonzero count
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.range_error) |-> (rsp.epoch_seconds == '0))
    else $error("range error with nonzero seconds");

  // a year past the top of the range is caught in the first stage
  a_year_high: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && (req.years_since_1900 > c2e_pkg::MaxYearOff)) |=> s1_err)
    else $error("year above range not flagged");

endmodule

### tb/sv/calendar_to_epoch_seconds_test.sv
// ----------------------------------------------------------------------------
// calendar_to_epoch_seconds_test
// Self-checking bench for the calendar to epoch seconds converter. A
// scoreboard predicts the seconds value and range flag of every accepted
// request and matches the results in order. A directed set covers the
// field limits and calendar corner cases. A random set of mostly in-range
// timestamps follows, with bursty requests and a stalling result side.
// ----------------------------------------------------------------------------
module calendar_to_epoch_seconds_test;

  // One broken-down timestamp as it travels on the request channel.
  typedef struct packed {
    logic [c2e_pkg::YearW-1:0] years;
    logic [c2e_pkg::MonW-1:0]  month;
    logic [c2e_pkg::DayW-1:0]  day;
    logic [c2e_pkg::HourW-1:0] hour;
    logic [c2e_pkg::MinW-1:0]  minute;
    logic [c2e_pkg::SecW-1:0]  second;
  } stamp_t;

  // One converted value as it comes back on the result channel.
  typedef struct packed {
    logic [c2e_pkg::SecsW-1:0] secs;
    logic                      err;
  } epoch_t;

  localparam int RandomStamps = 1100;
  localparam int DrainCycles  = 4 * c2e_pkg::NumStages;

  // --------------------------------------------------------------------------
  // Scoreboard: predict each accepted timestamp, hold the predictions in
  // arrival order and match them against the results.
  // --------------------------------------------------------------------------
  class epoch_scoreboard;
    epoch_t pending[$];
    int     mismatches;
    int     unexpected;
    int     checked;
    int     in_range;
    int     flagged;
    int     leap_shifted;

    function epoch_t predict(stamp_t s);
      epoch_t          e;
      longint unsigned y;
      longint unsigned days;
      bit              leap;
      e.secs = '0;
      e.err  = 1'b1;
      if (s.years < c2e_pkg::MinYearOff || s.years > c2e_pkg::MaxYearOff ||
          s.month > c2e_pkg::MaxMonth || s.day == 0 || s.day > c2e_pkg::MaxDay ||
          s.hour > c2e_pkg::MaxHour || s.minute > c2e_pkg::MaxMinute ||
          s.second > c2e_pkg::MaxSecond) begin
        return e;
      end
      y    = longint'(s.years) + 1900;
      leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
      // whole years since 1970, then leap days of 1972 .. y-1
      days = (y - 1970) * c2e_pkg::DaysPerYear + (y - 1969) / 4 - (y - 1901) / 100 +
             (y - 1601) / 400;
      case (s.month)
        1:  days += 31;
        2:  days += 59;
        3:  days += 90;
        4:  days += 120;
        5:  days += 151;
        6:  days += 181;
        7:  days += 212;
        8:  days += 243;
        9:  days += 273;
        10: days += 304;
        11: days += 334;
        default: ;
      endcase
      days += s.day - 1;
      if (s.month > c2e_pkg::Feb && leap) days += 1;
      e.secs = c2e_pkg::SecsW'(days * c2e_pkg::SecsPerDay + s.hour * c2e_pkg::SecsPerHour +
                               s.minute * c2e_pkg::SecsPerMin + s.second);
      e.err  = 1'b0;
      return e;
    endfunction

    function void note_stamp(stamp_t s);
      epoch_t e;
      e = predict(s);
      pending.push_back(e);
      if (e.err) flagged++;
      else in_range++;
      if (!e.err && s.month > c2e_pkg::Feb && (s.years % 4 == 0)) leap_shifted++;
    endfunction

    function void check_epoch(logic [c2e_pkg::SecsW-1:0] secs, logic err);
      epoch_t e;
      if (pending.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10)
          $display("unexpected result: secs=%0d err=%0b", secs, err);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (secs !== e.secs || err !== e.err) begin
        mismatches++;
        if (mismatches + unexpected <= 10)
          $display("mismatch on result %0d: expected secs=%0d err=%0b, got secs=%0d err=%0b",
                   checked, e.secs, e.err, secs, err);
      end
    endfunction

    function int failures();
      return mismatches + unexpected + pending.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  c2e_req_if req ();
  c2e_rsp_if rsp ();

  calendar_to_epoch_seconds dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  epoch_scoreboard sb = new();

  // requests left in the current burst before the sender takes a gap
  int burst_left = 0;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Result side: sample at the rising edge, before the block's own updates
  // land, and check every accepted transaction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) sb.check_epoch(rsp.epoch_seconds, rsp.range_error);
  end

  // Drive ready in phases, each picked at random as always ready, mostly
  // ready or mostly stalled, so results back up in the pipe.
  initial begin
    int phase_cycles;
    int mode;
    phase_cycles = 0;
    mode = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (phase_cycles == 0) begin
        mode = $urandom_range(0, 2);
        phase_cycles = 48;
      end
      phase_cycles--;
      case (mode)
        0: rsp.ready <= 1'b1;
        1: rsp.ready <= ($urandom_range(0, 3) != 0);
        default: rsp.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Build a timestamp from plain field values.
  function automatic stamp_t make_stamp(int years, int month, int day,
                                        int hour, int minute, int second);
    stamp_t s;
    s.years  = c2e_pkg::YearW'(years);
    s.month  = c2e_pkg::MonW'(month);
    s.day    = c2e_pkg::DayW'(day);
    s.hour   = c2e_pkg::HourW'(hour);
    s.minute = c2e_pkg::MinW'(minute);
    s.second = c2e_pkg::SecW'(second);
    return s;
  endfunction

  // Take a gap when the burst runs out; keep valid high inside a burst so it
  // is never dropped and raised in the same step.
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 6);
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 8);
    end
  endtask

  // Present one timestamp and hold it until the block takes it.
  task automatic send_stamp(stamp_t s);
    req.valid            <= 1'b1;
    req.years_since_1900 <= s.years;
    req.month_index      <= s.month;
    req.day_of_month     <= s.day;
    req.hour_of_day      <= s.hour;
    req.minute_of_hour   <= s.minute;
    req.second_of_minute <= s.second;
    do @(posedge clk); while (!req.ready);
    sb.note_stamp(s);
    pace();
  endtask

  // Hold the request side until every outstanding result has come back;
  // the wait always passes a clock edge so valid is not lowered and raised at once.
  task automatic drain();
    req.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  // Mostly in-range timestamps with random content; some carry one field
  // out of range, a few are raw bits across the full field widths.
  function automatic stamp_t random_stamp();
    stamp_t s;
    int     kind;
    int     pick;
    kind = $urandom_range(0, 99);
    pick = $urandom_range(0, 9);
    case (pick)
      0: s.years = c2e_pkg::YearW'($urandom_range(70, 75));
      1: s.years = c2e_pkg::YearW'($urandom_range(9990, 9999));
      2: s.years = c2e_pkg::YearW'(100 * $urandom_range(1, 99));
      default: s.years = c2e_pkg::YearW'($urandom_range(70, 9999));
    endcase
    s.month  = c2e_pkg::MonW'($urandom_range(0, 11));
    s.day    = c2e_pkg::DayW'($urandom_range(1, 31));
    s.hour   = c2e_pkg::HourW'($urandom_range(0, 23));
    s.minute = c2e_pkg::MinW'($urandom_range(0, 59));
    s.second = ($urandom_range(0, 9) == 0) ? c2e_pkg::SecW'(60) :
                                             c2e_pkg::SecW'($urandom_range(0, 59));
    if (kind >= 90) begin
      s = stamp_t'($urandom);
      s.years = c2e_pkg::YearW'($urandom);
    end else if (kind >= 75) begin
      case ($urandom_range(0, 6))
        0: s.years  = c2e_pkg::YearW'($urandom_range(0, 69));
        1: s.years  = c2e_pkg::YearW'($urandom_range(10000, 16383));
        2: s.month  = c2e_pkg::MonW'($urandom_range(12, 15));
        3: s.day    = ($urandom_range(0, 1) == 0) ? c2e_pkg::DayW'(0) :
                                                    c2e_pkg::DayW'($urandom_range(32, 63));
        4: s.hour   = c2e_pkg::HourW'($urandom_range(24, 31));
        5: s.minute = c2e_pkg::MinW'($urandom_range(60, 63));
        default: s.second = c2e_pkg::SecW'($urandom_range(61, 63));
      endcase
    end
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence: reset, directed corners, random traffic, drain, report.
  // --------------------------------------------------------------------------
  initial begin
    req.valid            <= 1'b0;
    req.years_since_1900 <= '0;
    req.month_index      <= '0;
    req.day_of_month     <= '0;
    req.hour_of_day      <= '0;
    req.minute_of_hour   <= '0;
    req.second_of_minute <= '0;
    rst <= 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // epoch itself and the last second of its first year
    send_stamp(make_stamp(70, 0, 1, 0, 0, 0));
    send_stamp(make_stamp(70, 11, 31, 23, 59, 59));
    // largest valid input, leap second included
    send_stamp(make_stamp(9999, 11, 31, 23, 59, 60));
    send_stamp(make_stamp(9999, 0, 1, 0, 0, 0));
    // second sixty rolls into the next minute
    send_stamp(make_stamp(72, 5, 30, 23, 59, 60));
    // first leap year: Feb 29 and the March shift
    send_stamp(make_stamp(72, 1, 29, 12, 0, 0));
    send_stamp(make_stamp(72, 2, 1, 0, 0, 0));
    // day past the month end rolls into the next month
    send_stamp(make_stamp(101, 1, 31, 0, 0, 0));
    send_stamp(make_stamp(101, 3, 31, 6, 30, 15));
    // century years: 2000 is leap, 2100 is not
    send_stamp(make_stamp(100, 2, 1, 0, 0, 0));
    send_stamp(make_stamp(200, 2, 1, 0, 0, 0));
    send_stamp(make_stamp(138, 0, 19, 3, 14, 7));
    // fields out of range: a stamp of zeros, then one at a time, then everything at once
    send_stamp(make_stamp(0, 0, 0, 0, 0, 0));
    send_stamp(make_stamp(69, 11, 31, 23, 59, 59));
    send_stamp(make_stamp(10000, 0, 1, 0, 0, 0));
    send_stamp(make_stamp(500, 12, 1, 0, 0, 0));
    send_stamp(make_stamp(500, 15, 1, 0, 0, 0));
    send_stamp(make_stamp(500, 6, 0, 0, 0, 0));
    send_stamp(make_stamp(500, 6, 32, 0, 0, 0));
    send_stamp(make_stamp(500, 6, 15, 24, 0, 0));
    send_stamp(make_stamp(500, 6, 15, 0, 60, 0));
    send_stamp(make_stamp(500, 6, 15, 0, 0, 61));
    send_stamp(make_stamp(16383, 15, 63, 31, 63, 63));

    // let the pipe empty completely before the random part
    drain();

    for (int n = 0; n < RandomStamps; n++) begin
      if (n == RandomStamps / 2) drain();
      send_stamp(random_stamp());
    end

    drain();
    repeat (DrainCycles) @(posedge clk);

    $display("%0d timestamps sent: %0d in range (%0d past February in a year divisible by 4),",
             sb.in_range + sb.flagged, sb.in_range, sb.leap_shifted);
    $display("%0d flagged out of range; %0d results checked, %0d mismatched, %0d unexpected",
             sb.flagged, sb.checked, sb.mismatches, sb.unexpected);
    if (sb.failures() == 0) begin
      $display("calendar_to_epoch_seconds_test: done, clean");
    end else begin
      if (sb.pending.size() != 0)
        $display("%0d expected results never arrived", sb.pending.size());
      $display("calendar_to_epoch_seconds_test: done, errors");
    end
    $finish;
  end

  // Stop a hung run; the slowest legal run is far shorter than this.
  initial begin
    #4000000;
    $display("timeout with %0d results outstanding", sb.pending.size());
    $display("calendar_to_epoch_seconds_test: done, errors");
    $finish;
  end

endmodule

### files.f
sv/c2e_pkg.sv
sv/c2e_if.sv
sv/c2e_flow.sv
sv/calendar_to_epoch_seconds.sv
tb/sv/calendar_to_epoch_seconds_test.sv
